FILE: sv/magma_block_cipher_unit_assert.svh
// Assertion macros for the Magma block cipher unit.
// Each macro expands to one labelled concurrent assertion on a clock and an active-low reset.
`ifndef MAGMA_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mbc_pkg.sv
// Constants, types and round functions of the Magma block cipher unit.
// Depends on nothing; the top level imports it.
package mbc_pkg;

    localparam int NumRounds = 32;
    localparam int NumKeys   = 8;
    localparam int HalfW     = 32;
    localparam int BlockW    = 64;
    localparam int KeyIdxW   = 3;
    localparam int RoundW    = 5;
    localparam int AddrW     = 5;
    localparam int DataW     = 32;
    localparam int RotAmt    = 11;
    localparam int EncLastFwd = 24;
    localparam int DecLastFwd = 8;

    localparam logic ActEncrypt = 1'b0;
    localparam logic ActDecrypt = 1'b1;

    typedef logic [HalfW-1:0] t_half;

    typedef struct packed {
        logic  dec;
        t_half hi;
        t_half lo;
    } t_stage;

    // Row 0 serves the top nibble of the word, row 7 the bottom one.
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'hF,4'hC,4'h2,4'hA,4'h6,4'h4,4'h5,4'h0,4'h7,4'h9,4'hE,4'hD,4'h1,4'hB,4'h8,4'h3},
        '{4'hB,4'h6,4'h3,4'h4,4'hC,4'hF,4'hE,4'h2,4'h7,4'hD,4'h8,4'h0,4'h5,4'hA,4'h9,4'h1},
        '{4'h1,4'hC,4'hB,4'h0,4'hF,4'hE,4'h6,4'h5,4'hA,4'hD,4'h4,4'h8,4'h9,4'h3,4'h7,4'h2},
        '{4'h1,4'h5,4'hE,4'hC,4'hA,4'h7,4'h0,4'hD,4'h6,4'h2,4'hB,4'h4,4'h9,4'h3,4'hF,4'h8},
        '{4'h0,4'hC,4'h8,4'h9,4'hD,4'h2,4'hA,4'hB,4'h7,4'h3,4'h6,4'h5,4'h4,4'hE,4'hF,4'h1},
        '{4'h8,4'h0,4'hF,4'h3,4'h2,4'h5,4'hE,4'hB,4'h1,4'hA,4'h4,4'h7,4'hC,4'h9,4'hD,4'h6},
        '{4'h3,4'h0,4'h6,4'hF,4'h1,4'hE,4'h9,4'h2,4'hD,4'h8,4'hC,4'h4,4'hB,4'hA,4'h5,4'h7},
        '{4'h1,4'hA,4'h6,4'h8,4'hF,4'hB,4'h0,4'h4,4'hC,4'h3,4'h5,4'h9,4'h7,4'hD,4'h2,4'hE}
    };

    // Key word used in a given round. The reversed part of the schedule
    // counts down, which is the bitwise complement of the low three bits.
    function automatic logic [KeyIdxW-1:0] key_idx(input logic [RoundW-1:0] rnd,
                                                   input logic dec);
        logic fwd;
        fwd = (dec == ActDecrypt) ? (rnd < RoundW'(DecLastFwd))
                                  : (rnd < RoundW'(EncLastFwd));
        return fwd ? rnd[KeyIdxW-1:0] : ~rnd[KeyIdxW-1:0];
    endfunction

    function automatic t_half round_fn(input t_half half, input t_half key);
        t_half sum;
        t_half sub;
        sum = half + key;
        for (int j = 0; j < 8; j++) begin
            sub[HalfW-4-4*j +: 4] = SBOX[j][sum[HalfW-4-4*j +: 4]];
        end
        return {sub[HalfW-1-RotAmt:0], sub[HalfW-1:HalfW-RotAmt]};
    endfunction

endpackage

FILE: sv/magma_block_cipher_unit.sv
// Magma 64-bit block cipher, fully unrolled: one Feistel round per pipeline stage.
// Depends on mbc_pkg and on magma_block_cipher_unit_assert.svh for its assertions.
//
//   Channel   Handshake                      Payload
//   -------   ----------------------------   -----------------------------
//   command   start, busy                    i_action, i_block_in
//   result    o_done (one-cycle strobe)      o_block_out
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item leaves after passing in order through the 32 round stage registers,
// one per round; a new item may enter in every cycle, so busy stays low.
// Reset clears the stage valid bits and the eight key words.
// The receiver cannot stall, so the pipeline never holds an item back.
`include "magma_block_cipher_unit_assert.svh"

module magma_block_cipher_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [mbc_pkg::BlockW-1:0]   i_block_in,
    output logic                         o_done,
    output logic [mbc_pkg::BlockW-1:0]   o_block_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbc_pkg::AddrW-1:0]    paddr,
    input  logic [mbc_pkg::DataW-1:0]    pwdata,
    output logic [mbc_pkg::DataW-1:0]    prdata,
    output logic                         pready
);
    import mbc_pkg::*;

    t_half                r_key   [NumKeys];
    logic [NumRounds-1:0] r_valid;
    logic [NumRounds-1:0] n_valid;
    t_stage               r_stage [NumRounds];
    t_stage               n_stage [NumRounds];
    t_stage               stage_in[NumRounds];
    logic                 cfg_wr;
    logic [KeyIdxW-1:0]   cfg_idx;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[AddrW-1:2];
    assign prdata  = r_key[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumKeys; k++) begin
                r_key[k] <= '0;
            end
        end else if (cfg_wr) begin
            r_key[cfg_idx] <= pwdata;
        end
    end

    always_comb begin
        n_valid = {r_valid[NumRounds-2:0], start && !busy};
        stage_in[0] = '{dec: i_action, hi: i_block_in[BlockW-1:HalfW],
                        lo: i_block_in[HalfW-1:0]};
        for (int s = 1; s < NumRounds; s++) begin
            stage_in[s] = r_stage[s-1];
        end
        for (int s = 0; s < NumRounds; s++) begin
            n_stage[s].dec = stage_in[s].dec;
            if (s == NumRounds - 1) begin
                // The final round leaves the halves in place.
                n_stage[s].hi = stage_in[s].hi;
                n_stage[s].lo = stage_in[s].lo ^ round_fn(stage_in[s].hi,
                                r_key[key_idx(RoundW'(s), stage_in[s].dec)]);
            end else begin
                n_stage[s].hi = stage_in[s].lo ^ round_fn(stage_in[s].hi,
                                r_key[key_idx(RoundW'(s), stage_in[s].dec)]);
                n_stage[s].lo = stage_in[s].hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NumRounds; s++) begin
            r_stage[s] <= n_stage[s];
        end
    end

    assign o_done      = r_valid[NumRounds-1];
    assign o_block_out = {r_stage[NumRounds-1].hi, r_stage[NumRounds-1].lo};

    `MBC_ASSERT_SAME(a_done_has_source, i_clk, i_rst_n, o_done,
        $past(start && !busy, NumRounds), "result item without an accepted item")
    `MBC_ASSERT_NEXT(a_valid_shifts, i_clk, i_rst_n, 1'b1,
        r_valid[NumRounds-1:1] == $past(r_valid[NumRounds-2:0]),
        "stage valid bits did not advance together")
    `MBC_ASSERT_NEXT(a_key_written, i_clk, i_rst_n, cfg_wr,
        r_key[$past(cfg_idx)] == $past(pwdata), "key word write lost")

endmodule
